// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers for the median filter window checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property on an explicit clock and reset.
`define MFW_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property on the usual clock and reset names.
`define MFW_ASSERT(label, prop, msg) `MFW_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== sv/mfw_pkg.sv =====
`timescale 1ns / 1ps
package mfw_pkg;

   localparam int MAX_RADIUS = 2;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int PIXEL_BITS = 16;

   localparam int SLOTS   = 2 * MAX_RADIUS + 2;
   localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

   localparam int COL_W  = 11;
   localparam int ROW_W  = 13;
   localparam int RAD_W  = 2;
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ADDR_W = SLOT_W + XW;
   localparam int CNT_W  = $clog2(WIN_MAX + 1);
   localparam int SIDE_W = $clog2(2 * MAX_RADIUS + 2);
   localparam int CSR_W  = ROW_W;
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS = 2'd2;

   typedef struct packed {
      logic                  command;
      logic [PIXEL_BITS-1:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS:0] median_half;
      logic                frame_last;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic drop;
   } sort_ctrl_type;

   typedef struct packed {
      logic                done;
      logic [PIXEL_BITS:0] median_half;
   } sort_stat_type;

endpackage

// ===== sv/median_filter_window.sv =====
`timescale 1ns / 1ps
// Streaming 2-D median filter over a square window clipped to the frame edges.
// Pixels enter in raster order; one result per item at most, in raster order,
// and flush items drain results still pending after the last pixel. Items are
// handled one at a time: each is checked for a ready output, and one that yields
// a result reads its clipped window of n pixels (up to 25; n may be zero), then
// drops the smaller half and waits for any previous result to leave on rsp_stall.
// The work is paced by the single read port of the line store, which feeds one
// window pixel per cycle into the insertion sorter, and by the drop of the
// smaller half of the sorted window. median_half is twice the median, the sum of
// the two middle values when n is even. The result register lets the next item
// be taken while a result waits on rsp_stall.
module median_filter_window (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mfw_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mfw_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [mfw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mfw_pkg::CSR_W-1:0]            csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LAST  = 3'd3;
   localparam logic [2:0] ST_DROP  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam int COL_W  = mfw_pkg::COL_W;
   localparam int ROW_W  = mfw_pkg::ROW_W;
   localparam int RAD_W  = mfw_pkg::RAD_W;
   localparam int SLOT_W = mfw_pkg::SLOT_W;
   localparam int SIDE_W = mfw_pkg::SIDE_W;
   localparam int XW     = mfw_pkg::XW;

   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  width_ff, width_in;
   logic [ROW_W-1:0]  height_ff, height_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;

   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic              in_frame_ff, in_frame_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic              out_frame_ff, out_frame_in;

   logic [SIDE_W-1:0] nrows_ff, nrows_in;
   logic [SIDE_W-1:0] ncols_ff, ncols_in;
   logic [SIDE_W-1:0] row_cnt_ff, row_cnt_in;
   logic [SIDE_W-1:0] col_cnt_ff, col_cnt_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [XW-1:0]     cur_col_ff, cur_col_in;
   logic [XW-1:0]     start_col_ff, start_col_in;
   logic              rd_pend_ff, rd_pend_in;

   logic              rsp_valid_ff, rsp_valid_in;
   mfw_pkg::rsp_type  rsp_ff, rsp_in;

   logic [COL_W-1:0]  eff_w, wm1;
   logic [ROW_W-1:0]  eff_h, hm1;
   logic [RAD_W-1:0]  eff_r;
   logic [ROW_W:0]    lr_full;
   logic [ROW_W-1:0]  lr;
   logic [COL_W:0]    lc_full;
   logic [COL_W-1:0]  lc;
   logic              out_ready;
   logic [RAD_W-1:0]  up, left;
   logic [ROW_W-1:0]  row_lo, row_span;
   logic [COL_W-1:0]  col_lo, col_span;
   logic              win_empty;
   logic [SLOT_W-1:0] start_slot;
   logic              frame_last;

   logic              accept;
   logic              wr_en, rd_en;
   logic [mfw_pkg::ADDR_W-1:0]     wr_addr, rd_addr;
   logic [mfw_pkg::PIXEL_BITS-1:0] rd_data;
   mfw_pkg::sort_ctrl_type         sort_ctrl;
   mfw_pkg::sort_stat_type         sort_stat;

   // Effective configuration
   always_comb begin
      eff_w = width_ff;
      if (width_ff == '0) begin
         eff_w = COL_W'(1);
      end else if (width_ff > COL_W'(mfw_pkg::MAX_WIDTH)) begin
         eff_w = COL_W'(mfw_pkg::MAX_WIDTH);
      end
      eff_h = height_ff;
      if (height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (height_ff > ROW_W'(mfw_pkg::MAX_HEIGHT)) begin
         eff_h = ROW_W'(mfw_pkg::MAX_HEIGHT);
      end
      eff_r = (radius_ff > RAD_W'(mfw_pkg::MAX_RADIUS)) ? RAD_W'(mfw_pkg::MAX_RADIUS)
                                                         : radius_ff;
      wm1 = eff_w - 1'b1;
      hm1 = eff_h - 1'b1;
   end

   // Next output is ready once its bottom-right window corner has arrived.
   always_comb begin
      lr_full   = {1'b0, out_row_ff} + (ROW_W + 1)'(eff_r);
      lr        = (lr_full > {1'b0, hm1}) ? hm1 : lr_full[ROW_W-1:0];
      lc_full   = {1'b0, out_col_ff} + (COL_W + 1)'(eff_r);
      lc        = (lc_full > {1'b0, wm1}) ? wm1 : lc_full[COL_W-1:0];
      out_ready = (in_frame_ff != out_frame_ff) || (in_row_ff > lr)
                  || ((in_row_ff == lr) && (in_col_ff > lc));
   end

   // Clipped window extent around the output position
   always_comb begin
      up        = (out_row_ff < ROW_W'(eff_r)) ? out_row_ff[RAD_W-1:0] : eff_r;
      left      = (out_col_ff < COL_W'(eff_r)) ? out_col_ff[RAD_W-1:0] : eff_r;
      row_lo    = out_row_ff - ROW_W'(up);
      col_lo    = out_col_ff - COL_W'(left);
      // counters left past a shrunk frame can leave nothing inside the window
      win_empty = (lr < row_lo) || (lc < col_lo);
      row_span  = lr - row_lo;
      col_span  = lc - col_lo;
      start_slot = (out_slot_ff >= SLOT_W'(up))
                   ? out_slot_ff - SLOT_W'(up)
                   : out_slot_ff + SLOT_W'(mfw_pkg::SLOTS) - SLOT_W'(up);
      frame_last = ({1'b0, out_col_ff} + 1'b1 >= {1'b0, eff_w})
                   && ({1'b0, out_row_ff} + 1'b1 >= {1'b0, eff_h});
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      radius_in    = radius_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_slot_in   = in_slot_ff;
      in_frame_in  = in_frame_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_slot_in  = out_slot_ff;
      out_frame_in = out_frame_ff;
      nrows_in     = nrows_ff;
      ncols_in     = ncols_ff;
      row_cnt_in   = row_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      cur_slot_in  = cur_slot_ff;
      cur_col_in   = cur_col_ff;
      start_col_in = start_col_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = {in_slot_ff, in_col_ff[XW-1:0]};
      rd_en        = 1'b0;
      rd_addr      = {cur_slot_ff, cur_col_ff};
      sort_ctrl    = '0;

      if (csr_we) begin
         case (csr_index)
            mfw_pkg::CSR_FRAME_WIDTH:   width_in  = csr_wdata[COL_W-1:0];
            mfw_pkg::CSR_FRAME_HEIGHT:  height_in = csr_wdata[ROW_W-1:0];
            mfw_pkg::CSR_WINDOW_RADIUS: radius_in = csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
               if (req_data.command == mfw_pkg::CMD_PIXEL) begin
                  wr_en = (in_col_ff < COL_W'(mfw_pkg::MAX_WIDTH));
                  if ({1'b0, in_col_ff} + 1'b1 >= {1'b0, eff_w}) begin
                     in_col_in  = '0;
                     in_slot_in = (in_slot_ff == SLOT_W'(mfw_pkg::SLOTS - 1))
                                  ? '0 : in_slot_ff + 1'b1;
                     if ({1'b0, in_row_ff} + 1'b1 >= {1'b0, eff_h}) begin
                        in_row_in   = '0;
                        in_frame_in = !in_frame_ff;
                     end else begin
                        in_row_in = in_row_ff + 1'b1;
                     end
                  end else begin
                     in_col_in = in_col_ff + 1'b1;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (out_ready) begin
               sort_ctrl.clear = 1'b1;
               nrows_in     = SIDE_W'(row_span) + 1'b1;
               ncols_in     = SIDE_W'(col_span) + 1'b1;
               row_cnt_in   = '0;
               col_cnt_in   = '0;
               cur_slot_in  = start_slot;
               start_col_in = XW'(col_lo);
               cur_col_in   = XW'(col_lo);
               state_in     = win_empty ? ST_LAST : ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rd_en      = 1'b1;
            rd_pend_in = 1'b1;
            if (col_cnt_ff == ncols_ff - 1'b1) begin
               col_cnt_in  = '0;
               cur_col_in  = start_col_ff;
               cur_slot_in = (cur_slot_ff == SLOT_W'(mfw_pkg::SLOTS - 1))
                             ? '0 : cur_slot_ff + 1'b1;
               row_cnt_in  = row_cnt_ff + 1'b1;
               if (row_cnt_ff == nrows_ff - 1'b1) begin
                  state_in = ST_LAST;
               end
            end else begin
               col_cnt_in = col_cnt_ff + 1'b1;
               cur_col_in = cur_col_ff + 1'b1;
            end
         end
         ST_LAST: begin
            // final read data is inserted in this cycle
            state_in = ST_DROP;
         end
         ST_DROP: begin
            if (sort_stat.done) begin
               state_in = ST_EMIT;
            end else begin
               sort_ctrl.drop = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.median_half = sort_stat.median_half;
               rsp_in.frame_last  = frame_last;
               state_in           = ST_IDLE;
               if ({1'b0, out_col_ff} + 1'b1 >= {1'b0, eff_w}) begin
                  out_col_in  = '0;
                  out_slot_in = (out_slot_ff == SLOT_W'(mfw_pkg::SLOTS - 1))
                                ? '0 : out_slot_ff + 1'b1;
                  if ({1'b0, out_row_ff} + 1'b1 >= {1'b0, eff_h}) begin
                     out_row_in   = '0;
                     out_frame_in = !out_frame_ff;
                  end else begin
                     out_row_in = out_row_ff + 1'b1;
                  end
               end else begin
                  out_col_in = out_col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      sort_ctrl.insert = rd_pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= COL_W'(640);
         height_ff    <= ROW_W'(480);
         radius_ff    <= RAD_W'(1);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         in_frame_ff  <= 1'b0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         out_frame_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         radius_ff    <= radius_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         in_frame_ff  <= in_frame_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         out_frame_ff <= out_frame_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nrows_ff     <= nrows_in;
      ncols_ff     <= ncols_in;
      row_cnt_ff   <= row_cnt_in;
      col_cnt_ff   <= col_cnt_in;
      cur_slot_ff  <= cur_slot_in;
      cur_col_ff   <= cur_col_in;
      start_col_ff <= start_col_in;
      rsp_ff       <= rsp_in;
   end

   mfw_line_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.pixel_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfw_sorter u_sorter (
      .clock (clock),
      .reset (reset),
      .ctrl  (sort_ctrl),
      .din   (rd_data),
      .stat  (sort_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/mfw_line_store.sv =====
`timescale 1ns / 1ps
module mfw_line_store (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [mfw_pkg::ADDR_W-1:0]          wr_addr,
   input  logic [mfw_pkg::PIXEL_BITS-1:0]      wr_data,
   input  logic                                rd_en,
   input  logic [mfw_pkg::ADDR_W-1:0]          rd_addr,
   output logic [mfw_pkg::PIXEL_BITS-1:0]      rd_data
);

   logic [mfw_pkg::PIXEL_BITS-1:0] mem_ff [0:mfw_pkg::SLOTS*mfw_pkg::MAX_WIDTH-1];
   logic [mfw_pkg::PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mfw_sorter.sv =====
`timescale 1ns / 1ps
module mfw_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  mfw_pkg::sort_ctrl_type           ctrl,
   input  logic [mfw_pkg::PIXEL_BITS-1:0]   din,
   output mfw_pkg::sort_stat_type           stat
);

   logic [mfw_pkg::PIXEL_BITS-1:0] s_ff [mfw_pkg::WIN_MAX];
   logic [mfw_pkg::PIXEL_BITS-1:0] s_in [mfw_pkg::WIN_MAX];
   logic [mfw_pkg::CNT_W-1:0]      k_ff, k_in;
   logic [mfw_pkg::CNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [mfw_pkg::WIN_MAX-1:0]    gt;
   logic [mfw_pkg::CNT_W-1:0]      drop_need;

   // Ascending insertion: entries above the new value shift up by one.
   always_comb begin
      for (int p = 0; p < mfw_pkg::WIN_MAX; p++) begin
         gt[p] = (mfw_pkg::CNT_W'(p) < k_ff) && (s_ff[p] > din);
      end
      for (int p = 0; p < mfw_pkg::WIN_MAX; p++) begin
         s_in[p] = s_ff[p];
         if (ctrl.insert) begin
            if (p > 0 && gt[(p > 0) ? p - 1 : 0]) begin
               s_in[p] = s_ff[(p > 0) ? p - 1 : 0];
            end else if (gt[p] || mfw_pkg::CNT_W'(p) >= k_ff) begin
               s_in[p] = din;
            end
         end else if (ctrl.drop) begin
            if (p < mfw_pkg::WIN_MAX - 1) begin
               s_in[p] = s_ff[(p < mfw_pkg::WIN_MAX - 1) ? p + 1 : p];
            end
         end
      end
      k_in    = k_ff;
      dcnt_in = dcnt_ff;
      if (ctrl.clear) begin
         k_in    = '0;
         dcnt_in = '0;
      end else if (ctrl.insert) begin
         k_in = k_ff + 1'b1;
      end else if (ctrl.drop) begin
         dcnt_in = dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         dcnt_ff <= '0;
      end else begin
         k_ff    <= k_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   // Drop the (k-1)/2 smallest; the median then sits at the bottom.
   assign drop_need = (k_ff - 1'b1) >> 1;

   always_comb begin
      stat.done = (k_ff == '0) || (dcnt_ff == drop_need);
      if (k_ff == '0) begin
         stat.median_half = '0;
      end else if (k_ff[0]) begin
         stat.median_half = {s_ff[0], 1'b0};
      end else begin
         stat.median_half = {1'b0, s_ff[0]} + {1'b0, s_ff[1]};
      end
   end

endmodule

// ===== sv/mfw_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mfw_pkg::rsp_type rsp_data
);

   // A waiting result holds until taken.
   `MFW_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "rsp item changed while stalled")

   // One item at a time: the block is busy right after taking one.
   `MFW_ASSERT(a_one_item, (req_valid && !req_stall) |=> req_stall, "item taken while busy")

   // A new result is only produced while an item is being worked on.
   `MFW_ASSERT(a_rsp_from_work, $rose(rsp_valid) |-> $past(req_stall), "result without work")

endmodule

bind median_filter_window mfw_checker u_mfw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_median_filter_window.sv =====
`timescale 1ns / 1ps
module tb_median_filter_window;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int RANDOM_ITEMS   = 950;

   class median_scoreboard;
      bit [mfw_pkg::PIXEL_BITS-1:0] ring [mfw_pkg::SLOTS][mfw_pkg::MAX_WIDTH];
      int unsigned width_reg = 640, height_reg = 480, radius_reg = 1;
      int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot;
      bit in_frame, out_frame;
      mfw_pkg::rsp_type expected_q[$];
      int unsigned pending_px;
      int errors;

      function int eff_w();
         if (width_reg < 1) return 1;
         if (width_reg > mfw_pkg::MAX_WIDTH) return mfw_pkg::MAX_WIDTH;
         return width_reg;
      endfunction

      function int eff_h();
         if (height_reg < 1) return 1;
         if (height_reg > mfw_pkg::MAX_HEIGHT) return mfw_pkg::MAX_HEIGHT;
         return height_reg;
      endfunction

      function int eff_r();
         return (radius_reg > mfw_pkg::MAX_RADIUS) ? mfw_pkg::MAX_RADIUS : radius_reg;
      endfunction

      function void set_reg(logic [mfw_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
         case (idx)
            mfw_pkg::CSR_FRAME_WIDTH:   width_reg  = val & 'h7ff;
            mfw_pkg::CSR_FRAME_HEIGHT:  height_reg = val & 'h1fff;
            mfw_pkg::CSR_WINDOW_RADIUS: radius_reg = val & 'h3;
            default: ;
         endcase
      endfunction

      function bit window_complete();
         int lr, lc;
         lr = out_row + eff_r();
         lc = out_col + eff_r();
         if (in_frame != out_frame) return 1;
         if (lr > eff_h() - 1) lr = eff_h() - 1;
         if (lc > eff_w() - 1) lc = eff_w() - 1;
         if (int'(in_row) > lr) return 1;
         return int'(in_row) == lr && int'(in_col) > lc;
      endfunction

      function logic [mfw_pkg::PIXEL_BITS:0] window_median();
         int unsigned vals[mfw_pkg::WIN_MAX];
         int unsigned v;
         int n, j, r, rlo, rhi, clo, chi, slot;
         n = 0;
         r = eff_r();
         rlo = (int'(out_row) - r < 0) ? 0 : int'(out_row) - r;
         rhi = (int'(out_row) + r > eff_h() - 1) ? eff_h() - 1 : int'(out_row) + r;
         clo = (int'(out_col) - r < 0) ? 0 : int'(out_col) - r;
         chi = (int'(out_col) + r > eff_w() - 1) ? eff_w() - 1 : int'(out_col) + r;
         for (int y = rlo; y <= rhi; y++) begin
            slot = (int'(out_slot) + mfw_pkg::SLOTS + (y - int'(out_row))) % mfw_pkg::SLOTS;
            for (int x = clo; x <= chi; x++) begin
               v = ring[slot][x];
               // insertion sort as the window fills
               j = n - 1;
               while (j >= 0 && vals[j] > v) begin
                  vals[j + 1] = vals[j];
                  j--;
               end
               vals[j + 1] = v;
               n++;
            end
         end
         if (n == 0) return '0;
         if (n % 2 == 1) return (mfw_pkg::PIXEL_BITS + 1)'(2 * vals[n / 2]);
         return (mfw_pkg::PIXEL_BITS + 1)'(vals[n / 2 - 1] + vals[n / 2]);
      endfunction

      function void note(mfw_pkg::req_type item);
         mfw_pkg::rsp_type res;
         if (item.command == mfw_pkg::CMD_PIXEL) begin
            ring[in_slot][in_col] = item.pixel_value;
            pending_px++;
            if (in_col + 1 >= eff_w()) begin
               in_col = 0;
               in_slot = (in_slot + 1) % mfw_pkg::SLOTS;
               if (in_row + 1 >= eff_h()) begin
                  in_row = 0;
                  in_frame ^= 1'b1;
               end else begin
                  in_row++;
               end
            end else begin
               in_col++;
            end
         end
         if (!window_complete()) return;
         res.median_half = window_median();
         res.frame_last = (out_col + 1 >= eff_w()) && (out_row + 1 >= eff_h());
         expected_q = {expected_q, res};
         pending_px--;
         if (out_col + 1 >= eff_w()) begin
            out_col = 0;
            out_slot = (out_slot + 1) % mfw_pkg::SLOTS;
            if (out_row + 1 >= eff_h()) begin
               out_row = 0;
               out_frame ^= 1'b1;
            end else begin
               out_row++;
            end
         end else begin
            out_col++;
         end
      endfunction

      function void check(mfw_pkg::rsp_type got);
         mfw_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result median_half %0d", got.median_half);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.median_half !== want.median_half) begin
            $error("median_half expected %0d actual %0d", want.median_half, got.median_half);
            errors++;
         end
         if (got.frame_last !== want.frame_last) begin
            $error("frame_last expected %0d actual %0d", want.frame_last, got.frame_last);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_we;
   mfw_pkg::req_type req_data;
   mfw_pkg::rsp_type rsp_data;
   logic [mfw_pkg::CSR_IDX_W-1:0] csr_index;
   logic [mfw_pkg::CSR_W-1:0] csr_wdata;

   median_scoreboard medians;
   int idle_pct, stall_pct, quiet_cycles, items_sent;

   median_filter_window i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) medians.check(rsp_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[median_filter_window] ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_item(logic cmd, logic [mfw_pkg::PIXEL_BITS-1:0] pix);
      mfw_pkg::req_type item;
      item.command = cmd;
      item.pixel_value = pix;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      medians.note(item);
      items_sent++;
   endtask

   function automatic logic [mfw_pkg::PIXEL_BITS-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return mfw_pkg::PIXEL_BITS'($urandom_range(100, 103));
         default: return mfw_pkg::PIXEL_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   // drain pending results, let the block settle, then load a new setting
   task automatic write_regs(int unsigned w, int unsigned h, int unsigned r);
      while (medians.pending_px > 0) send_item(mfw_pkg::CMD_FLUSH, mfw_pkg::PIXEL_BITS'($urandom));
      req_valid <= 1'b0;
      while (medians.expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= mfw_pkg::CSR_FRAME_WIDTH;
      csr_wdata <= mfw_pkg::CSR_W'(w);
      @(posedge clock);
      csr_index <= mfw_pkg::CSR_FRAME_HEIGHT;
      csr_wdata <= mfw_pkg::CSR_W'(h);
      @(posedge clock);
      csr_index <= mfw_pkg::CSR_WINDOW_RADIUS;
      csr_wdata <= mfw_pkg::CSR_W'(r);
      @(posedge clock);
      csr_we <= 1'b0;
      medians.set_reg(mfw_pkg::CSR_FRAME_WIDTH, mfw_pkg::CSR_W'(w));
      medians.set_reg(mfw_pkg::CSR_FRAME_HEIGHT, mfw_pkg::CSR_W'(h));
      medians.set_reg(mfw_pkg::CSR_WINDOW_RADIUS, mfw_pkg::CSR_W'(r));
   endtask

   task automatic run_frames(int frames, int flush_pct);
      int total;
      total = frames * medians.eff_w() * medians.eff_h();
      for (int k = 0; k < total; k++) begin
         while ($urandom_range(0, 99) < flush_pct) begin
            send_item(mfw_pkg::CMD_FLUSH, mfw_pkg::PIXEL_BITS'($urandom));
         end
         send_item(mfw_pkg::CMD_PIXEL, pick_pixel());
      end
   endtask

   initial begin
      int group;
      medians = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pixel frame, radius zero, then a flush with nothing ready
      write_regs(0, 1, 0);
      send_item(mfw_pkg::CMD_PIXEL, 16'hffff);
      send_item(mfw_pkg::CMD_FLUSH, 16'h0);
      // clipped windows at the inner columns give even counts; clamped radius
      write_regs(4, 3, 3);
      send_item(mfw_pkg::CMD_FLUSH, 16'hffff);
      for (int k = 0; k < 12; k++) begin
         send_item(mfw_pkg::CMD_PIXEL,
                   (k % 3 == 0) ? 16'hffff : mfw_pkg::PIXEL_BITS'(k));
      end
      write_regs(5, 2, 1);
      for (int k = 0; k < 10; k++) send_item(mfw_pkg::CMD_PIXEL, (k % 2) ? 16'h0 : 16'hffff);

      items_sent = 0;
      group = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case (group % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 66; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 66; end
            3: begin idle_pct = 19; stall_pct = 19; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         write_regs($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 3));
         run_frames($urandom_range(1, 3), 10);
         group++;
      end

      while (medians.pending_px > 0) send_item(mfw_pkg::CMD_FLUSH, mfw_pkg::PIXEL_BITS'($urandom));
      req_valid <= 1'b0;
      while (medians.expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (medians.errors == 0 && medians.expected_q.size() == 0) begin
         $display("[median_filter_window] OK");
      end else begin
         $display("[median_filter_window] ERROR");
      end
      $finish;
   end
endmodule
